@@ src/fpcc_pkg.sv @@
// Shared types and constants for the fire pixel color classifier.
// Holds the request/response payload structs, mode and CSR codes, and pipeline depth.
// No dependencies.
package fpcc_pkg;

   // pipeline: stage 0 is the input register, the last stage is the response register
   localparam int NUM_STAGES = 6;
   // datapath modules own the stages between the input and response registers
   localparam int DP_STAGES  = 4;

   // CSR index space
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 1'b1;

   // color modes (any other code passes the pixel through)
   localparam logic [1:0] MODE_HSV = 2'd0;
   localparam logic [1:0] MODE_YCC = 2'd1;

   localparam logic [7:0] MASK_ON  = 8'hFF;
   localparam logic [7:0] MASK_OFF = 8'h00;

   typedef struct packed {
      logic [7:0] in_blue;
      logic [7:0] in_green;
      logic [7:0] in_red;
   } req_type;

   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
   } rsp_type;

endpackage

@@ src/fire_pixel_color_classifier.sv @@
// Fire pixel color classifier: BGR pixel in, fire mask (or the pixel itself) out.
// A request accepted into stage 0 moves through stages 1 to 5 and shows on rsp_valid from the response register.
// Throughput: one request per cycle while rsp_stall is low; six register stages, each with its own valid bit.
// Stall: stages compact bubbles; req_stall rises only when every stage is full and
// rsp_stall is high. Reset clears the valid bits, color_mode to HSV, threshold to 0.
module fire_pixel_color_classifier (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  fpcc_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output fpcc_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [fpcc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fpcc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import fpcc_pkg::*;

   localparam int LAST = NUM_STAGES - 1;

   // configuration registers
   logic [1:0]            mode_in, mode_ff;
   logic [CSR_DATA_W-1:0] thr_in, thr_ff;

   always_comb begin
      mode_in = mode_ff;
      thr_in  = thr_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_COLOR_MODE: mode_in = csr_wdata[1:0];
            CSR_THRESHOLD:  thr_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_HSV;
         thr_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         thr_ff  <= thr_in;
      end
   end

   // per-stage ready: a stage loads when empty or when the one after it moves
   logic [NUM_STAGES:0]   stage_ready;
   logic [NUM_STAGES-1:0] valid_in, valid_ff;

   always_comb begin
      stage_ready[NUM_STAGES] = !rsp_stall;
      for (int k = LAST; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      valid_in[0] = stage_ready[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (stage_ready[k])
            valid_in[k] = valid_ff[k-1];
         else
            valid_in[k] = valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= valid_in;
   end

   // pixel carried along for pass mode
   req_type pix_ff [0:LAST-1];

   always_ff @(posedge clock) begin
      if (stage_ready[0]) pix_ff[0] <= req_data;
      for (int k = 1; k < LAST; k++) begin
         if (stage_ready[k]) pix_ff[k] <= pix_ff[k-1];
      end
   end

   // rule datapaths
   logic hsv_fire;
   logic ycc_fire;

   fpcc_hsv u_hsv (
      .clock     (clock),
      .stage_en  (stage_ready[DP_STAGES:1]),
      .pix       (pix_ff[0]),
      .threshold (thr_ff),
      .fire      (hsv_fire)
   );

   fpcc_ycc u_ycc (
      .clock     (clock),
      .stage_en  (stage_ready[DP_STAGES:1]),
      .pix       (pix_ff[0]),
      .threshold (thr_ff),
      .fire      (ycc_fire)
   );

   // response register: mask by mode, or the pixel unchanged
   rsp_type rsp_in, rsp_ff;

   always_comb begin
      case (mode_ff)
         MODE_HSV: begin
            rsp_in.out_blue  = hsv_fire ? MASK_ON : MASK_OFF;
            rsp_in.out_green = hsv_fire ? MASK_ON : MASK_OFF;
            rsp_in.out_red   = hsv_fire ? MASK_ON : MASK_OFF;
         end
         MODE_YCC: begin
            rsp_in.out_blue  = ycc_fire ? MASK_ON : MASK_OFF;
            rsp_in.out_green = ycc_fire ? MASK_ON : MASK_OFF;
            rsp_in.out_red   = ycc_fire ? MASK_ON : MASK_OFF;
         end
         default: begin
            rsp_in.out_blue  = pix_ff[LAST-1].in_blue;
            rsp_in.out_green = pix_ff[LAST-1].in_green;
            rsp_in.out_red   = pix_ff[LAST-1].in_red;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_ready[LAST]) rsp_ff <= rsp_in;
   end

   assign req_stall = !stage_ready[0];
   assign rsp_valid = valid_ff[LAST];
   assign rsp_data  = rsp_ff;

   // input stall only with a full pipe and a stalled response
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff) && rsp_stall)
      else $error("req_stall with an empty stage or no response stall");

   // with the response side open the last stage follows the one before it
   a_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |=> valid_ff[LAST] == $past(valid_ff[LAST-1]))
      else $error("response stage skipped or repeated a request");

   // a blocked input stage keeps its request
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !stage_ready[0] |=> valid_ff[0] && $stable(pix_ff[0]))
      else $error("input stage lost its request while blocked");

endmodule

@@ src/fpcc_hsv.sv @@
// HSV fire rule datapath: four register stages, fire flag out of the last one.
// Compares are exact integer cross-multiplications of the byte values.
// Depends on fpcc_pkg.
module fpcc_hsv (
   input  logic                                 clock,
   input  logic [fpcc_pkg::DP_STAGES-1:0]       stage_en,
   input  fpcc_pkg::req_type                    pix,
   input  logic [fpcc_pkg::CSR_DATA_W-1:0]      threshold,
   output logic                                 fire
);
   import fpcc_pkg::*;

   // which channel holds the maximum; ties go blue, then green, then red
   typedef enum logic [1:0] {
      MAX_BLUE  = 2'd0,
      MAX_GREEN = 2'd1,
      MAX_RED   = 2'd2
   } max_sel_type;

   // stage 1: max, min, delta, hue difference term
   logic [7:0]        mx;
   logic [7:0]        mn;
   max_sel_type       sel1_in, sel1_ff;
   logic [7:0]        mx1_in, mx1_ff;
   logic [7:0]        d1_in, d1_ff;
   logic signed [8:0] hdiff1_in, hdiff1_ff;

   always_comb begin
      mx = pix.in_red;
      mn = pix.in_red;
      if (pix.in_green > mx) mx = pix.in_green;
      if (pix.in_blue  > mx) mx = pix.in_blue;
      if (pix.in_green < mn) mn = pix.in_green;
      if (pix.in_blue  < mn) mn = pix.in_blue;
      mx1_in = mx;
      d1_in  = mx - mn;
      if (pix.in_blue == mx) begin
         sel1_in   = MAX_BLUE;
         hdiff1_in = $signed({1'b0, pix.in_red}) - $signed({1'b0, pix.in_green});
      end else if (pix.in_green == mx) begin
         sel1_in   = MAX_GREEN;
         hdiff1_in = $signed({1'b0, pix.in_blue}) - $signed({1'b0, pix.in_red});
      end else begin
         sel1_in   = MAX_RED;
         hdiff1_in = $signed({1'b0, pix.in_green}) - $signed({1'b0, pix.in_blue});
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         sel1_ff   <= sel1_in;
         mx1_ff    <= mx1_in;
         d1_ff     <= d1_in;
         hdiff1_ff <= hdiff1_in;
      end
   end

   // stage 2: hue numerator (wrapped positive), squares, 255*d
   logic [15:0]        base_d;
   logic signed [18:0] hn_raw;
   logic signed [18:0] hn_adj;
   logic [16:0]        hn2_in, hn2_ff;
   logic [15:0]        dd2_in, dd2_ff;
   logic [15:0]        mm2_in, mm2_ff;
   logic [15:0]        d255_2_in, d255_2_ff;
   logic [7:0]         mx2_ff;

   always_comb begin
      case (sel1_ff)
         MAX_BLUE:  base_d = 16'(d1_ff) * 16'd240;
         MAX_GREEN: base_d = 16'(d1_ff) * 16'd120;
         default:   base_d = 16'd0;
      endcase
      hn_raw = $signed({3'b0, base_d}) + 19'(hdiff1_ff) * 19'sd60;
      // negative hue wraps by a full turn
      if (hn_raw < 0)
         hn_adj = hn_raw + $signed({2'b0, 17'(d1_ff) * 17'd360});
      else
         hn_adj = hn_raw;
      hn2_in    = hn_adj[16:0];
      dd2_in    = 16'(d1_ff) * 16'(d1_ff);
      mm2_in    = 16'(mx1_ff) * 16'(mx1_ff);
      d255_2_in = 16'(d1_ff) * 16'd255;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         hn2_ff    <= hn2_in;
         dd2_ff    <= dd2_in;
         mm2_ff    <= mm2_in;
         d255_2_ff <= d255_2_in;
         mx2_ff    <= mx1_ff;
      end
   end

   // stage 3: value and saturation tests, hue cross products
   logic        sat_ok3_in, sat_ok3_ff;
   logic        val_ok3_in, val_ok3_ff;
   logic [24:0] lhs3_in, lhs3_ff;
   logic [24:0] rhs3_in, rhs3_ff;

   always_comb begin
      sat_ok3_in = mm2_ff > d255_2_ff;
      val_ok3_in = 24'(16'(mx2_ff) * 16'd200) > 24'(threshold) * 24'd255;
      lhs3_in    = 25'(dd2_ff) * 25'd400;
      rhs3_in    = 25'(hn2_ff) * 25'(mx2_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         sat_ok3_ff <= sat_ok3_in;
         val_ok3_ff <= val_ok3_in;
         lhs3_ff    <= lhs3_in;
         rhs3_ff    <= rhs3_in;
      end
   end

   // stage 4: final decision (zero delta gives 0 > 0, so black)
   logic fire4_in, fire4_ff;

   assign fire4_in = sat_ok3_ff && val_ok3_ff && (lhs3_ff > rhs3_ff);

   always_ff @(posedge clock) begin
      if (stage_en[3]) fire4_ff <= fire4_in;
   end

   assign fire = fire4_ff;

endmodule

@@ src/fpcc_ycc.sv @@
// YCbCr fire rule datapath: four register stages, fire flag decoded from the last one.
// Q.16 luma, Q.32 chroma, all compares exact.
// Depends on fpcc_pkg.
module fpcc_ycc (
   input  logic                                 clock,
   input  logic [fpcc_pkg::DP_STAGES-1:0]       stage_en,
   input  fpcc_pkg::req_type                    pix,
   input  logic [fpcc_pkg::CSR_DATA_W-1:0]      threshold,
   output logic                                 fire
);
   import fpcc_pkg::*;

   localparam logic [23:0]        Y_R_COEF  = 24'd19595;
   localparam logic [23:0]        Y_G_COEF  = 24'd38470;
   localparam logic [23:0]        Y_B_COEF  = 24'd7471;
   localparam logic signed [42:0] CB_COEF   = 43'sd36962;
   localparam logic signed [42:0] CR_COEF   = 43'sd46727;
   localparam logic signed [42:0] HALF_Q32  = 43'sd2147483648;

   // stage 1: luma in Q.16
   logic [23:0] y1_in, y1_ff;
   logic [7:0]  b1_ff;
   logic [7:0]  r1_ff;

   assign y1_in = 24'(pix.in_red) * Y_R_COEF + 24'(pix.in_green) * Y_G_COEF
                + 24'(pix.in_blue) * Y_B_COEF;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         y1_ff <= y1_in;
         b1_ff <= pix.in_blue;
         r1_ff <= pix.in_red;
      end
   end

   // stage 2: chroma differences, luma threshold test
   logic signed [25:0] eb2_in, eb2_ff;
   logic signed [25:0] er2_in, er2_ff;
   logic               y_ok2_in, y_ok2_ff;
   logic [23:0]        y2_ff;

   always_comb begin
      eb2_in   = $signed({2'b0, b1_ff, 16'b0}) - $signed({2'b0, y1_ff});
      er2_in   = $signed({2'b0, r1_ff, 16'b0}) - $signed({2'b0, y1_ff});
      y_ok2_in = {8'b0, y1_ff} > {threshold, 16'b0};
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         eb2_ff   <= eb2_in;
         er2_ff   <= er2_in;
         y_ok2_ff <= y_ok2_in;
         y2_ff    <= y1_ff;
      end
   end

   // stage 3: chroma products (offset left out, it cancels or is folded in)
   logic signed [42:0] cbp3_in, cbp3_ff;
   logic signed [42:0] crp3_in, crp3_ff;
   logic               y_ok3_ff;
   logic [23:0]        y3_ff;

   assign cbp3_in = 43'(eb2_ff) * CB_COEF;
   assign crp3_in = 43'(er2_ff) * CR_COEF;

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         cbp3_ff  <= cbp3_in;
         crp3_ff  <= crp3_in;
         y_ok3_ff <= y_ok2_ff;
         y3_ff    <= y2_ff;
      end
   end

   // stage 4: Y >= Cb, Cr >= Cb, chroma difference
   logic signed [42:0] ylim;
   logic               lum_ok4_in, lum_ok4_ff;
   logic               crcb_ok4_in, crcb_ok4_ff;
   logic signed [43:0] diff4_in, diff4_ff;
   logic               y_ok4_ff;

   always_comb begin
      // Y32 >= Cb32  <=>  Y16 << 16 - 2^31 >= Cb product
      ylim        = $signed({3'b0, y3_ff, 16'b0}) - HALF_Q32;
      lum_ok4_in  = ylim >= cbp3_ff;
      crcb_ok4_in = crp3_ff >= cbp3_ff;
      diff4_in    = 44'(cbp3_ff) - 44'(crp3_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         lum_ok4_ff  <= lum_ok4_in;
         crcb_ok4_ff <= crcb_ok4_in;
         diff4_ff    <= diff4_in;
         y_ok4_ff    <= y_ok3_ff;
      end
   end

   // 255*|diff| > thr << 32, tested on both signs instead of taking abs
   logic signed [51:0] diff255;
   logic signed [51:0] thr_q32;

   always_comb begin
      diff255 = (52'(diff4_ff) <<< 8) - 52'(diff4_ff);
      thr_q32 = $signed({4'b0, threshold, 32'b0});
      fire    = y_ok4_ff && lum_ok4_ff && crcb_ok4_ff
             && ((diff255 > thr_q32) || (diff255 < -thr_q32));
   end

endmodule

@@ tb/sv/fire_pixel_color_classifier_tb.sv @@
// Testbench for fire_pixel_color_classifier: directed corner pixels, then random phases
// over every color mode and a mix of thresholds, checked against an in-bench mask predictor.
// Depends on fpcc_pkg and the fire_pixel_color_classifier RTL.
`timescale 1ns / 1ps

module fire_pixel_color_classifier_tb;
   import fpcc_pkg::*;

   // pass-through codes (anything that is neither HSV nor YCbCr)
   localparam logic [1:0] MODE_PASS     = 2'd2;
   localparam logic [1:0] MODE_PASS_ALT = 2'd3;
   localparam int PHASE_REQUESTS = 125;
   localparam int RANDOM_PHASES  = 10;
   localparam int PRESSURE_AT    = 500;
   localparam int PRESSURE_HOLD  = 64;

   // predicts the mask for each accepted request and checks responses in order
   class fire_mask_scoreboard;
      localparam longint Q16_SCALE = 64'sd65536;
      localparam longint Q32_HALF  = 64'sd2147483648;
      localparam longint Q32_SCALE = 64'sd4294967296;
      logic [1:0]  mode;
      logic [15:0] thr;
      rsp_type     expected_masks[$];
      int          errors;
      int          accepted;

      function new();
         mode     = MODE_HSV;
         thr      = '0;
         errors   = 0;
         accepted = 0;
      endfunction

      // HSV rule by exact cross-multiplication; ties go blue, then green, then red
      function bit hsv_fire(longint r, longint g, longint b);
         longint mx, mn, d, hn, t;
         t  = longint'(thr);
         mx = r; mn = r;
         if (g > mx) mx = g;
         if (b > mx) mx = b;
         if (g < mn) mn = g;
         if (b < mn) mn = b;
         d = mx - mn;
         if (d == 0) return 1'b0;  // grey: no hue, no saturation
         if (b == mx) hn = 240 * d + 60 * (r - g);
         else if (g == mx) hn = 120 * d + 60 * (b - r);
         else hn = 60 * (g - b);
         if (hn < 0) hn += 360 * d;
         return (200 * mx > 255 * t) && (mx * mx > 255 * d) && (400 * d * d > hn * mx);
      endfunction

      // YCbCr rule: Y in Q.16, Cb and Cr in Q.32, all compares exact
      function bit ycc_fire(longint r, longint g, longint b);
         longint y16, y32, cb32, cr32, diff, t;
         t    = longint'(thr);
         y16  = 19595 * r + 38470 * g + 7471 * b;
         y32  = y16 * Q16_SCALE;
         cb32 = (b * Q16_SCALE - y16) * 36962 + Q32_HALF;
         cr32 = (r * Q16_SCALE - y16) * 46727 + Q32_HALF;
         diff = cb32 - cr32;
         if (diff < 0) diff = -diff;
         return (y16 > t * Q16_SCALE) && (y32 >= cb32) && (cr32 >= cb32) &&
                (255 * diff > t * Q32_SCALE);
      endfunction

      function rsp_type classify(req_type p);
         rsp_type res;
         bit      fire;
         if (mode == MODE_HSV)
            fire = hsv_fire(longint'(p.in_red), longint'(p.in_green), longint'(p.in_blue));
         else if (mode == MODE_YCC)
            fire = ycc_fire(longint'(p.in_red), longint'(p.in_green), longint'(p.in_blue));
         else begin
            res.out_blue  = p.in_blue;
            res.out_green = p.in_green;
            res.out_red   = p.in_red;
            return res;
         end
         res.out_blue  = fire ? MASK_ON : MASK_OFF;
         res.out_green = fire ? MASK_ON : MASK_OFF;
         res.out_red   = fire ? MASK_ON : MASK_OFF;
         return res;
      endfunction

      function void note_pixel(req_type p);
         expected_masks.push_back(classify(p));
         accepted++;
      endfunction

      function void check_mask(rsp_type got);
         rsp_type exp_mask;
         if (expected_masks.size() == 0) begin
            $error("unexpected response: blue %0d green %0d red %0d",
                   got.out_blue, got.out_green, got.out_red);
            errors++;
            return;
         end
         exp_mask = expected_masks.pop_front();
         if (got.out_blue !== exp_mask.out_blue) begin
            $error("out_blue: expected %0d, got %0d", exp_mask.out_blue, got.out_blue);
            errors++;
         end
         if (got.out_green !== exp_mask.out_green) begin
            $error("out_green: expected %0d, got %0d", exp_mask.out_green, got.out_green);
            errors++;
         end
         if (got.out_red !== exp_mask.out_red) begin
            $error("out_red: expected %0d, got %0d", exp_mask.out_red, got.out_red);
            errors++;
         end
      endfunction

      function int pending();
         return expected_masks.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   fire_mask_scoreboard masks = new();

   fire_pixel_color_classifier uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // generous run limit
   initial begin
      #2_000_000;
      $display("fire_pixel_color_classifier_tb failed");
      $finish;
   end

   // offer one request and hold it until accepted
   task automatic send_pixel(input req_type p);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall);
      masks.note_pixel(p);
   endtask

   // drop valid, with junk on the bus
   task automatic sender_gap(input int n);
      @(negedge clock);
      req_valid <= 1'b0;
      req_data  <= req_type'(24'($urandom));
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic wait_drained();
      while (masks.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_COLOR_MODE) masks.mode = val[1:0];
      else masks.thr = val;
   endtask

   // mode write carries random upper bits, which the block must ignore
   task automatic set_config(input logic [1:0] mode, input logic [15:0] thr);
      sender_gap(1);
      wait_drained();
      write_csr(CSR_COLOR_MODE, {14'($urandom), mode});
      write_csr(CSR_THRESHOLD, thr);
   endtask

   function automatic logic [15:0] pick_threshold();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(0, 300));
      endcase
   endfunction

   // mix of uniform, fire-like, grey/tied and saturated pixels
   function automatic req_type pick_pixel();
      req_type p;
      int      v;
      p = req_type'(24'($urandom));
      case ($urandom_range(0, 3))
         1: begin
            p.in_red   = 8'($urandom_range(150, 255));
            p.in_green = 8'($urandom_range(40, p.in_red));
            p.in_blue  = 8'($urandom_range(0, p.in_green));
         end
         2: begin
            v = $urandom_range(0, 255);
            case ($urandom_range(0, 3))
               0: begin p.in_blue = 8'(v); p.in_green = 8'(v); p.in_red = 8'(v); end
               1: begin p.in_blue = 8'(v); p.in_green = 8'(v); end
               2: begin p.in_green = 8'(v); p.in_red = 8'(v); end
               default: begin p.in_blue = 8'(v); p.in_red = 8'(v); end
            endcase
         end
         3: begin
            if ($urandom_range(0, 1)) p.in_blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            if ($urandom_range(0, 1)) p.in_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            if ($urandom_range(0, 1)) p.in_red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         default: ;
      endcase
      return p;
   endfunction

   // bursts of random length with random gaps, sometimes none
   task automatic run_phase(input int count);
      int left, burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 40);
         if (burst > left) burst = left;
         repeat (burst) send_pixel(pick_pixel());
         left -= burst;
         if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 6));
      end
   endtask

   // response check at the rising edge
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) masks.check_mask(rsp_data);

   // receiver stall pattern, with one long hold-off to back the pipe up
   initial begin
      int  style, seg, k, hold_left;
      bit  held;
      rsp_stall = 1'b0;
      held      = 1'b0;
      hold_left = 0;
      forever begin
         style = $urandom_range(0, 3);
         seg   = $urandom_range(20, 80);
         for (k = 0; k < seg; k++) begin
            @(negedge clock);
            if (!held && masks.accepted >= PRESSURE_AT) begin
               held      = 1'b1;
               hold_left = PRESSURE_HOLD;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_stall <= 1'b1;
            end else begin
               case (style)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 9) < 3);
                  2: rsp_stall <= ($urandom_range(0, 9) < 7);
                  default: rsp_stall <= ~rsp_stall;
               endcase
            end
         end
      end
   end

   // main sequence
   initial begin
      req_type    corner[11];
      logic [1:0] fixed_mode[8];
      logic [15:0] fixed_thr[8];
      int         i, ph;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_COLOR_MODE;
      csr_wdata = '0;

      // blue, green, red
      corner = '{
         '{8'd0,   8'd0,   8'd0},    // black
         '{8'd255, 8'd255, 8'd255},  // white
         '{8'd128, 8'd128, 8'd128},  // grey, zero delta
         '{8'd0,   8'd0,   8'd255},  // pure red
         '{8'd0,   8'd255, 8'd0},    // pure green
         '{8'd255, 8'd0,   8'd0},    // pure blue
         '{8'd20,  8'd140, 8'd255},  // flame orange
         '{8'd200, 8'd200, 8'd50},   // blue/green tie at max
         '{8'd30,  8'd220, 8'd220},  // green/red tie at max
         '{8'd180, 8'd60,  8'd180},  // blue/red tie at max
         '{8'd90,  8'd10,  8'd250}   // red max, blue over green: hue wraps
      };
      fixed_mode = '{MODE_HSV, MODE_HSV, MODE_HSV, MODE_YCC,
                     MODE_YCC, MODE_YCC, MODE_PASS, MODE_PASS_ALT};
      fixed_thr  = '{16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // corners at reset config (HSV, threshold 0), then YCbCr, then pass-through
      for (i = 0; i < 11; i++) send_pixel(corner[i]);
      set_config(MODE_YCC, 16'd0);
      for (i = 0; i < 11; i++) send_pixel(corner[i]);
      set_config(MODE_PASS_ALT, 16'hFFFF);
      for (i = 0; i < 3; i++) send_pixel(corner[i]);

      // random phases: fixed extremes first, then random settings
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph < 8) begin
            if (fixed_thr[ph] == 16'd0 && ph != 0 && ph != 3)
               set_config(fixed_mode[ph], pick_threshold());
            else
               set_config(fixed_mode[ph], fixed_thr[ph]);
         end else
            set_config(2'($urandom), pick_threshold());
         run_phase(PHASE_REQUESTS);
      end

      sender_gap(1);
      wait_drained();
      repeat (20) @(posedge clock);
      if (masks.errors == 0)
         $display("fire_pixel_color_classifier_tb passed");
      else
         $display("fire_pixel_color_classifier_tb failed");
      $finish;
   end

endmodule
